// File: rtl/hnm_pkg.sv
// Shared types, constants and the colour mapping for the height to normal map block.
// Used by the stream interfaces and the top level; depends on nothing else.
package hnm_pkg;

    // field widths
    localparam int COORD_W    = 10;
    localparam int PIX_W      = 8;
    localparam int CFG_DIM_W  = 11;
    localparam int SCALE_W    = 16;
    localparam int DIFF_W     = PIX_W + 1;
    localparam int PROD_W     = SCALE_W + DIFF_W;

    // default geometry limits
    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 1024;

    // register reset values
    localparam logic [CFG_DIM_W-1:0]      RST_WIDTH  = 11'd256;
    localparam logic [CFG_DIM_W-1:0]      RST_HEIGHT = 11'd256;
    localparam logic signed [SCALE_W-1:0] RST_SCALE  = 16'sd4096;

    // register port
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = 2;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_WIDTH  = 2'd0,
        REG_HEIGHT = 2'd1,
        REG_SCALE  = 2'd2
    } t_reg_idx;

    // colour mapping constants: colour = floor(255 * (4096 - p) / 8192)
    localparam logic [PIX_W-1:0]        COLOUR_FULL = 8'hFF;
    localparam logic signed [PROD_W:0]  ONE_Q12     = 26'sd4096;
    localparam logic signed [PROD_W:0]  SAT_T       = 26'sd8225;
    localparam int                      T_W         = 14;
    localparam int                      HALF_SHIFT  = 13;

    // one pending result before colour mapping
    typedef struct packed {
        logic [COORD_W-1:0] px;
        logic [COORD_W-1:0] py;
        logic [PIX_W-1:0]   centre;
        logic [PIX_W-1:0]   right;
        logic [PIX_W-1:0]   below;
        logic               done;
        logic               last;
    } t_slot;

    // a result after the scale multiply
    typedef struct packed {
        logic [COORD_W-1:0]       px;
        logic [COORD_W-1:0]       py;
        logic signed [PROD_W-1:0] p_red;
        logic signed [PROD_W-1:0] p_green;
        logic                     done;
        logic                     last;
    } t_prod;

    // scaled slope to saturated colour channel
    function automatic logic [PIX_W-1:0] slope_colour(input logic signed [PROD_W-1:0] p);
        logic signed [PROD_W:0] t;
        logic [T_W+PIX_W-1:0]   m;
        logic [PIX_W-1:0]       res;
        t = ONE_Q12 - {p[PROD_W-1], p};
        m = {t[T_W-1:0], {PIX_W{1'b0}}} - {{PIX_W{1'b0}}, t[T_W-1:0]};
        if (t <= 0) begin
            res = '0;
        end else if (t >= SAT_T) begin
            res = COLOUR_FULL;
        end else begin
            res = m[HALF_SHIFT+PIX_W-1:HALF_SHIFT];
        end
        return res;
    endfunction

endpackage

// File: rtl/hnm_in_if.sv
// Height sample stream channel with valid/ready handshake.
// Depends on hnm_pkg for the sample width.
interface hnm_in_if;
    logic                      valid;
    logic                      ready;
    logic [hnm_pkg::PIX_W-1:0] height_value;

    modport source (output valid, output height_value, input ready);
    modport sink   (input valid, input height_value, output ready);
endinterface

// File: rtl/hnm_out_if.sv
// Normal map result stream channel with valid/ready handshake.
// Depends on hnm_pkg for coordinate and colour widths.
interface hnm_out_if;
    logic                        valid;
    logic                        ready;
    logic [hnm_pkg::COORD_W-1:0] pixel_x;
    logic [hnm_pkg::COORD_W-1:0] pixel_y;
    logic [hnm_pkg::PIX_W-1:0]   normal_red;
    logic [hnm_pkg::PIX_W-1:0]   normal_green;
    logic [hnm_pkg::PIX_W-1:0]   normal_blue;
    logic [hnm_pkg::PIX_W-1:0]   normal_alpha;
    logic                        run_last;
    logic                        frame_done;

    modport source (output valid, output pixel_x, output pixel_y, output normal_red,
                    output normal_green, output normal_blue, output normal_alpha,
                    output run_last, output frame_done, input ready);
    modport sink   (input valid, input pixel_x, input pixel_y, input normal_red,
                    input normal_green, input normal_blue, input normal_alpha,
                    input run_last, input frame_done, output ready);
endinterface

// File: rtl/height_to_normal_map.sv
// Path: results pass the slot, product and output registers. Throughput: one sample per cycle
// above the last row while the output is not stalled; the last row gives up to two results
// per sample (three at frame end) and a new sample waits until at most one result is pending.
// Reset: synchronous, active low; clears counters, row bank, pipeline valids, registers to
// defaults. Line stores are not cleared. Uses hnm_pkg, hnm_in_if and hnm_out_if.
module height_to_normal_map #(
    parameter int MAX_WIDTH  = hnm_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = hnm_pkg::DEF_MAX_HEIGHT
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [hnm_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [hnm_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [hnm_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready,
    hnm_in_if.sink                          i_height,
    hnm_out_if.source                       o_normal
);

    localparam int XA_W    = $clog2(MAX_WIDTH);
    localparam int YA_W    = $clog2(MAX_HEIGHT);
    localparam int WD_W    = $clog2(MAX_WIDTH + 1);
    localparam int HD_W    = $clog2(MAX_HEIGHT + 1);
    localparam int WC_W    = (WD_W > hnm_pkg::CFG_DIM_W) ? WD_W : hnm_pkg::CFG_DIM_W;
    localparam int HC_W    = (HD_W > hnm_pkg::CFG_DIM_W) ? HD_W : hnm_pkg::CFG_DIM_W;
    localparam int RM_DEPTH = 2 ** (XA_W + 1);
    localparam int PIX_W   = hnm_pkg::PIX_W;
    localparam int COORD_W = hnm_pkg::COORD_W;

    // configuration registers
    logic [hnm_pkg::CFG_DIM_W-1:0]      r_width;
    logic [hnm_pkg::CFG_DIM_W-1:0]      r_height;
    logic signed [hnm_pkg::SCALE_W-1:0] r_scale;
    hnm_pkg::t_reg_idx                  reg_idx;
    logic                               cfg_wr;
    logic                               cfg_restart;

    // position and line store control
    logic [XA_W-1:0] r_col;
    logic [YA_W-1:0] r_row;
    logic            r_bank;
    logic [WD_W-1:0] w_eff;
    logic [HD_W-1:0] h_eff;
    logic [WC_W-1:0] w_ext;
    logic [WC_W-1:0] w_lim;
    logic [HC_W-1:0] h_ext;
    logic [HC_W-1:0] h_lim;
    logic            col_last;
    logic            row_last;
    logic            in_acc;
    logic [PIX_W-1:0] v;

    // line stores and prefetch registers
    logic [PIX_W-1:0] row_mem [RM_DEPTH];
    logic [PIX_W-1:0] first_mem [MAX_WIDTH];
    logic [XA_W:0]    rd_addr;
    logic [XA_W-1:0]  f_addr;
    logic [WD_W:0]    col_p2;
    logic [XA_W-1:0]  xr2;
    logic [PIX_W-1:0] r_rd_data;
    logic             r_byp;
    logic [PIX_W-1:0] r_byp_val;
    logic [PIX_W-1:0] prev_right;
    logic [PIX_W-1:0] r_pc;
    logic [PIX_W-1:0] r_cur0;
    logic [PIX_W-1:0] r_last_v;
    logic [PIX_W-1:0] r_fc;
    logic [PIX_W-1:0] r_fl;

    // coordinates of the results
    logic [XA_W-1:0]         col_m1;
    logic [YA_W-1:0]         row_m1;
    logic [COORD_W+XA_W-1:0] x_ext;
    logic [COORD_W+XA_W-1:0] xm_ext;
    logic [COORD_W+YA_W-1:0] y_ext;
    logic [COORD_W+YA_W-1:0] ym_ext;

    // pending results of the accepted sample
    hnm_pkg::t_slot r_slot [3];
    hnm_pkg::t_slot new_slot [3];
    logic [2:0]     r_mask;
    logic [2:0]     new_mask;
    logic [2:0]     low_bit;
    hnm_pkg::t_slot sel;
    logic           emit;

    // colour pipeline
    hnm_pkg::t_prod              r_p;
    logic                        r_p_valid;
    logic signed [hnm_pkg::DIFF_W-1:0] d_red;
    logic signed [hnm_pkg::DIFF_W-1:0] d_green;
    logic signed [hnm_pkg::PROD_W-1:0] p_red;
    logic signed [hnm_pkg::PROD_W-1:0] p_green;
    logic                        p_take;
    logic                        o_take;
    logic                        r_o_valid;
    logic [COORD_W-1:0]          r_o_x;
    logic [COORD_W-1:0]          r_o_y;
    logic [PIX_W-1:0]            r_o_red;
    logic [PIX_W-1:0]            r_o_green;
    logic                        r_o_done;
    logic                        r_o_last;

    // register port decode
    assign reg_idx     = hnm_pkg::t_reg_idx'(paddr[hnm_pkg::APB_ADDR_W-1:2]);
    assign cfg_wr      = psel && penable && pwrite;
    assign cfg_restart = cfg_wr && (reg_idx == hnm_pkg::REG_WIDTH ||
                                    reg_idx == hnm_pkg::REG_HEIGHT ||
                                    reg_idx == hnm_pkg::REG_SCALE);
    assign pready      = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= hnm_pkg::RST_WIDTH;
            r_height <= hnm_pkg::RST_HEIGHT;
            r_scale  <= hnm_pkg::RST_SCALE;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                hnm_pkg::REG_WIDTH:  r_width  <= pwdata[hnm_pkg::CFG_DIM_W-1:0];
                hnm_pkg::REG_HEIGHT: r_height <= pwdata[hnm_pkg::CFG_DIM_W-1:0];
                hnm_pkg::REG_SCALE:  r_scale  <= pwdata[hnm_pkg::SCALE_W-1:0];
                default: ;
            endcase
        end
    end

    // register read back
    always_comb begin
        unique case (reg_idx)
            hnm_pkg::REG_WIDTH:  prdata = hnm_pkg::APB_DATA_W'(r_width);
            hnm_pkg::REG_HEIGHT: prdata = hnm_pkg::APB_DATA_W'(r_height);
            hnm_pkg::REG_SCALE:  prdata = hnm_pkg::APB_DATA_W'($unsigned(r_scale));
            default:             prdata = '0;
        endcase
    end

    // dimensions in use, limited to 2..max
    always_comb begin
        w_ext = WC_W'(r_width);
        priority if (w_ext < WC_W'(2)) begin
            w_lim = WC_W'(2);
        end else if (w_ext > WC_W'(MAX_WIDTH)) begin
            w_lim = WC_W'(MAX_WIDTH);
        end else begin
            w_lim = w_ext;
        end
        h_ext = HC_W'(r_height);
        priority if (h_ext < HC_W'(2)) begin
            h_lim = HC_W'(2);
        end else if (h_ext > HC_W'(MAX_HEIGHT)) begin
            h_lim = HC_W'(MAX_HEIGHT);
        end else begin
            h_lim = h_ext;
        end
    end

    assign w_eff    = w_lim[WD_W-1:0];
    assign h_eff    = h_lim[HD_W-1:0];
    assign col_last = (WD_W'(r_col) == w_eff - WD_W'(1));
    assign row_last = (HD_W'(r_row) == h_eff - HD_W'(1));
    assign in_acc   = i_height.valid && i_height.ready;
    assign v        = i_height.height_value;

    // raster position and row bank
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_row  <= '0;
            r_bank <= 1'b0;
        end else if (cfg_restart) begin
            r_col <= '0;
            r_row <= '0;
        end else if (in_acc) begin
            if (col_last) begin
                r_col  <= '0;
                r_row  <= row_last ? '0 : r_row + 1'b1;
                r_bank <= ~r_bank;
            end else begin
                r_col <= r_col + 1'b1;
            end
        end
    end

    // prefetch addresses: next right neighbour from the row above, next first-row sample
    always_comb begin
        col_p2 = (WD_W+1)'(r_col) + (WD_W+1)'(2);
        xr2    = (col_p2 == (WD_W+1)'(w_eff)) ? '0 : col_p2[XA_W-1:0];
        if (col_last) begin
            rd_addr = {r_bank, XA_W'(1)};
            f_addr  = '0;
        end else begin
            rd_addr = {~r_bank, xr2};
            f_addr  = r_col + 1'b1;
        end
    end

    // ping-pong row store: current row written, row above read ahead
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            row_mem[{r_bank, r_col}] <= v;
            r_rd_data <= row_mem[rd_addr];
            r_byp     <= col_last && (r_col == XA_W'(1));
            r_byp_val <= v;
        end
    end

    assign prev_right = r_byp ? r_byp_val : r_rd_data;

    // first row store and its read-ahead pair
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            if (r_row == '0) begin
                first_mem[r_col] <= v;
            end
            r_fc <= first_mem[f_addr];
            r_fl <= r_fc;
        end
    end

    // centre of the row above, column 0 and left sample of the current row
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_pc     <= col_last ? r_cur0 : prev_right;
            r_last_v <= v;
            if (r_col == '0) begin
                r_cur0 <= v;
            end
        end
    end

    // coordinates, low bits only
    assign col_m1 = r_col - 1'b1;
    assign row_m1 = r_row - 1'b1;
    assign x_ext  = {{COORD_W{1'b0}}, r_col};
    assign xm_ext = {{COORD_W{1'b0}}, col_m1};
    assign y_ext  = {{COORD_W{1'b0}}, r_row};
    assign ym_ext = {{COORD_W{1'b0}}, row_m1};

    // results caused by the sample at the current position
    always_comb begin
        new_mask[0] = (r_row != '0);
        new_mask[1] = row_last && (r_col != '0);
        new_mask[2] = row_last && col_last;

        new_slot[0].px     = x_ext[COORD_W-1:0];
        new_slot[0].py     = ym_ext[COORD_W-1:0];
        new_slot[0].centre = r_pc;
        new_slot[0].right  = prev_right;
        new_slot[0].below  = v;
        new_slot[0].done   = 1'b0;
        new_slot[0].last   = !new_mask[1] && !new_mask[2];

        new_slot[1].px     = xm_ext[COORD_W-1:0];
        new_slot[1].py     = y_ext[COORD_W-1:0];
        new_slot[1].centre = r_last_v;
        new_slot[1].right  = v;
        new_slot[1].below  = r_fl;
        new_slot[1].done   = 1'b0;
        new_slot[1].last   = !new_mask[2];

        new_slot[2].px     = x_ext[COORD_W-1:0];
        new_slot[2].py     = y_ext[COORD_W-1:0];
        new_slot[2].centre = v;
        new_slot[2].right  = r_cur0;
        new_slot[2].below  = r_fc;
        new_slot[2].done   = 1'b1;
        new_slot[2].last   = 1'b1;
    end

    // oldest pending result goes first
    assign low_bit = r_mask & (~r_mask + 3'd1);

    always_comb begin
        priority if (r_mask[0]) begin
            sel = r_slot[0];
        end else if (r_mask[1]) begin
            sel = r_slot[1];
        end else begin
            sel = r_slot[2];
        end
    end

    // handshake chain through the pipeline
    assign o_take         = !r_o_valid || o_normal.ready;
    assign p_take         = !r_p_valid || o_take;
    assign emit           = (r_mask != 3'b0) && p_take;
    assign i_height.ready = (r_mask == low_bit) && ((r_mask == 3'b0) || p_take);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask <= '0;
        end else if (in_acc) begin
            r_mask <= new_mask;
        end else if (emit) begin
            r_mask <= r_mask & ~low_bit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_slot <= new_slot;
        end
    end

    // slope products
    assign d_red   = {1'b0, sel.right} - {1'b0, sel.centre};
    assign d_green = {1'b0, sel.below} - {1'b0, sel.centre};
    assign p_red   = r_scale * d_red;
    assign p_green = r_scale * d_green;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
        end else if (p_take) begin
            r_p_valid <= emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_p.px      <= sel.px;
            r_p.py      <= sel.py;
            r_p.p_red   <= p_red;
            r_p.p_green <= p_green;
            r_p.done    <= sel.done;
            r_p.last    <= sel.last;
        end
    end

    // colour mapping into the output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (o_take) begin
            r_o_valid <= r_p_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take && r_p_valid) begin
            r_o_x     <= r_p.px;
            r_o_y     <= r_p.py;
            r_o_red   <= hnm_pkg::slope_colour(r_p.p_red);
            r_o_green <= hnm_pkg::slope_colour(r_p.p_green);
            r_o_done  <= r_p.done;
            r_o_last  <= r_p.last;
        end
    end

    assign o_normal.valid        = r_o_valid;
    assign o_normal.pixel_x      = r_o_x;
    assign o_normal.pixel_y      = r_o_y;
    assign o_normal.normal_red   = r_o_red;
    assign o_normal.normal_green = r_o_green;
    assign o_normal.normal_blue  = hnm_pkg::COLOUR_FULL;
    assign o_normal.normal_alpha = hnm_pkg::COLOUR_FULL;
    assign o_normal.run_last     = r_o_last;
    assign o_normal.frame_done   = r_o_done;

    // a sample is only taken when at most one earlier result is still pending
    a_pending_on_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |-> (r_mask == low_bit))
        else $error("sample accepted with several results pending");

    // the frame end result closes its run
    a_done_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_normal.valid && o_normal.frame_done) |-> o_normal.run_last)
        else $error("frame end result not marked last");

    // position stays inside the frame in use
    a_pos_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (WD_W'(r_col) < w_eff) && (HD_W'(r_row) < h_eff))
        else $error("raster position outside frame");

endmodule

// File: verif/testbench.sv
// Self-checking bench for height_to_normal_map: drives height samples and register writes,
// predicts every normal map pixel in step with the stream and compares each one as it leaves.
// Depends on hnm_pkg, hnm_in_if, hnm_out_if and the height_to_normal_map top level.
module testbench;
    import hnm_pkg::*;

    localparam int MAX_W        = DEF_MAX_WIDTH;
    localparam int MAX_H        = DEF_MAX_HEIGHT;
    localparam int DRAIN_CYCLES = 10;
    localparam int LIMIT_CYCLES = 200000;
    localparam int ITEMS_PER_MODE = 100;
    localparam int LARGE_SAMPLES  = 24;
    localparam logic [APB_ADDR_W-1:0] UNUSED_REG_ADDR = 4'hC;

    // one expected normal map pixel
    typedef struct {
        logic [COORD_W-1:0] px;
        logic [COORD_W-1:0] py;
        logic [PIX_W-1:0]   red;
        logic [PIX_W-1:0]   green;
        logic [PIX_W-1:0]   blue;
        logic [PIX_W-1:0]   alpha;
        logic               last;
        logic               done;
    } t_normal_pix;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    hnm_in_if  height_ch ();
    hnm_out_if normal_ch ();

    height_to_normal_map DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .i_height (height_ch),
        .o_normal (normal_ch)
    );

    // predictor state: registers, line stores and stream position
    logic [CFG_DIM_W-1:0]      cfg_width;
    logic [CFG_DIM_W-1:0]      cfg_height;
    logic signed [SCALE_W-1:0] height_scale_q12;
    logic [PIX_W-1:0]          row_first [MAX_W];
    logic [PIX_W-1:0]          row_prev  [MAX_W];
    logic [PIX_W-1:0]          row_now   [MAX_W];
    int                        next_col;
    int                        next_row;

    t_normal_pix pending_normals[$];
    int          mismatch_count;
    int          cycle_count;
    int          sender_idle_pct;
    int          receiver_stall_pct;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int dim_in_use(input logic [CFG_DIM_W-1:0] raw, input int max_dim);
        if (raw < 2) begin
            return 2;
        end
        if (raw > max_dim) begin
            return max_dim;
        end
        return int'(raw);
    endfunction

    // floor(255*(4096 - s*d)/8192), saturated to a colour channel
    function automatic logic [PIX_W-1:0] colour_from_slope(input logic [PIX_W-1:0] centre,
                                                           input logic [PIX_W-1:0] neighbour);
        longint diff;
        longint prod;
        longint num;
        diff = longint'(neighbour) - longint'(centre);
        prod = longint'(height_scale_q12) * diff;
        num  = 255 * (4096 - prod);
        if (num <= 0) begin
            return '0;
        end
        if (num / 8192 > 255) begin
            return COLOUR_FULL;
        end
        return PIX_W'(num / 8192);
    endfunction

    function automatic t_normal_pix make_pixel(input int px, input int py,
                                               input logic [PIX_W-1:0] centre,
                                               input logic [PIX_W-1:0] right_h,
                                               input logic [PIX_W-1:0] below_h,
                                               input logic done);
        t_normal_pix p;
        p.px    = COORD_W'(px);
        p.py    = COORD_W'(py);
        p.red   = colour_from_slope(centre, right_h);
        p.green = colour_from_slope(centre, below_h);
        p.blue  = COLOUR_FULL;
        p.alpha = COLOUR_FULL;
        p.last  = 1'b0;
        p.done  = done;
        return p;
    endfunction

    // work out the pixels completed by one accepted height sample
    task automatic predict_normals(input logic [PIX_W-1:0] hv);
        int          w;
        int          hgt;
        int          x;
        int          y;
        int          xr;
        int          n;
        t_normal_pix res [3];
        w   = dim_in_use(cfg_width, MAX_W);
        hgt = dim_in_use(cfg_height, MAX_H);
        x   = (next_col >= w) ? w - 1 : next_col;
        y   = (next_row >= hgt) ? hgt - 1 : next_row;
        n   = 0;
        row_now[x] = hv;
        if (y == 0) begin
            row_first[x] = hv;
        end
        // pixel above now has its lower neighbour
        if (y >= 1) begin
            xr = (x + 1 == w) ? 0 : x + 1;
            res[n] = make_pixel(x, y - 1, row_prev[x], row_prev[xr], hv, 1'b0);
            n++;
        end
        // last row: left pixel now has its right neighbour, lower wraps to row 0
        if (y == hgt - 1 && x >= 1) begin
            res[n] = make_pixel(x - 1, y, row_now[x - 1], row_now[x], row_first[x - 1], 1'b0);
            n++;
        end
        // bottom-right pixel closes the frame
        if (y == hgt - 1 && x == w - 1) begin
            res[n] = make_pixel(x, y, row_now[x], row_now[0], row_first[x], 1'b1);
            n++;
        end
        if (n > 0) begin
            res[n - 1].last = 1'b1;
        end
        for (int i = 0; i < n; i++) begin
            pending_normals.push_back(res[i]);
        end
        x++;
        if (x >= w) begin
            x = 0;
            row_prev = row_now;
            y++;
            if (y >= hgt) begin
                y = 0;
            end
        end
        next_col = x;
        next_row = y;
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatch_count++;
        end
    endtask

    // watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // predict on each accepted sample, compare each accepted normal request
    always @(posedge i_clk) begin : stream_monitor
        t_normal_pix want;
        if (i_rst_n) begin
            if (height_ch.valid && height_ch.ready) begin
                predict_normals(height_ch.height_value);
            end
            if (normal_ch.valid && normal_ch.ready) begin
                if (pending_normals.size() == 0) begin
                    $error("unexpected normal request at (%0d,%0d)",
                           normal_ch.pixel_x, normal_ch.pixel_y);
                    mismatch_count++;
                end else begin
                    want = pending_normals.pop_front();
                    check_field("pixel_x", want.px, normal_ch.pixel_x);
                    check_field("pixel_y", want.py, normal_ch.pixel_y);
                    check_field("normal_red", want.red, normal_ch.normal_red);
                    check_field("normal_green", want.green, normal_ch.normal_green);
                    check_field("normal_blue", want.blue, normal_ch.normal_blue);
                    check_field("normal_alpha", want.alpha, normal_ch.normal_alpha);
                    check_field("run_last", want.last, normal_ch.run_last);
                    check_field("frame_done", want.done, normal_ch.frame_done);
                end
            end
        end
    end

    // receiver back-pressure
    always @(negedge i_clk) begin
        normal_ch.ready = ($urandom_range(0, 99) >= receiver_stall_pct);
    end

    task automatic send_height(input logic [PIX_W-1:0] hv);
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            @(negedge i_clk);
            height_ch.valid = 1'b0;
        end
        @(negedge i_clk);
        height_ch.valid        = 1'b1;
        height_ch.height_value = hv;
        do @(posedge i_clk); while (!height_ch.ready);
    endtask

    // stop sending and let every pending pixel and the pipeline drain
    task automatic wait_idle();
        @(negedge i_clk);
        height_ch.valid = 1'b0;
        while (pending_normals.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [APB_ADDR_W-1:0] reg_addr(input t_reg_idx idx);
        return APB_ADDR_W'({idx, 2'b00});
    endfunction

    task automatic write_register(input logic [APB_ADDR_W-1:0] addr,
                                  input logic [APB_DATA_W-1:0] data);
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = addr;
        pwdata  = data;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        // any listed register restarts the frame
        if (addr == reg_addr(REG_WIDTH)) begin
            cfg_width = data[CFG_DIM_W-1:0];
            next_col  = 0;
            next_row  = 0;
        end else if (addr == reg_addr(REG_HEIGHT)) begin
            cfg_height = data[CFG_DIM_W-1:0];
            next_col   = 0;
            next_row   = 0;
        end else if (addr == reg_addr(REG_SCALE)) begin
            height_scale_q12 = data[SCALE_W-1:0];
            next_col         = 0;
            next_row         = 0;
        end
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // all three registers, with junk in the unused upper bits
    task automatic write_geometry(input int w, input int hgt, input logic signed [15:0] s);
        wait_idle();
        write_register(reg_addr(REG_WIDTH),
                       ($urandom() & ~32'h7FF) | APB_DATA_W'(w & 32'h7FF));
        write_register(reg_addr(REG_HEIGHT),
                       ($urandom() & ~32'h7FF) | APB_DATA_W'(hgt & 32'h7FF));
        write_register(reg_addr(REG_SCALE), ($urandom() & 32'hFFFF_0000) | {16'h0, s});
    endtask

    // samples at the reset geometry stay on row 0 and complete nothing
    task automatic test_reset_defaults();
        send_height(8'h00);
        send_height(8'hFF);
    endtask

    // 2x2 frames with height extremes and mixed heights under unit, extreme and small scales
    task automatic test_tiny_frames();
        sender_idle_pct    = 24;
        receiver_stall_pct = 48;
        write_geometry(2, 2, 16'sd4096);
        send_height(8'h00); send_height(8'hFF); send_height(8'hFF); send_height(8'h00);
        write_geometry(2, 2, 16'sh7FFF);
        send_height(8'hFF); send_height(8'h00); send_height(8'h00); send_height(8'hFF);
        write_geometry(2, 2, 16'sh8000);
        send_height(8'h00); send_height(8'hFF); send_height(8'h80); send_height(8'h01);
        write_geometry(2, 2, 16'sd37);
        send_height(8'h0A); send_height(8'hC8); send_height(8'h5A); send_height(8'h3C);
    endtask

    // widths and heights below the minimum are used as 2
    task automatic test_dimension_limits();
        write_geometry(0, 1, 16'sd4096);
        send_height(8'h10); send_height(8'h7F); send_height(8'h55); send_height(8'hAA);
    endtask

    // a write outside the register list leaves the frame running
    task automatic test_unused_register();
        write_geometry(3, 2, 16'sd300);
        send_height(8'h20); send_height(8'hE0);
        wait_idle();
        write_register(UNUSED_REG_ADDR, $urandom());
        send_height(8'h33); send_height(8'h01); send_height(8'hFE); send_height(8'h90);
    endtask

    // widest and tallest frame settings, register values above the maximum
    task automatic test_largest_frames();
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        write_geometry(2047, 2, 16'($urandom()));
        repeat (LARGE_SAMPLES) send_height(8'($urandom()));
        write_geometry(2, 1500, 16'($urandom()));
        repeat (LARGE_SAMPLES) send_height(8'($urandom()));
    endtask

    // random geometries and scales, mostly whole frames with random content
    task automatic test_random_traffic(input int send_pct, input int recv_pct);
        int                  sent;
        int                  items;
        int                  w;
        int                  hgt;
        int                  pick;
        int                  ramp;
        logic [PIX_W-1:0]    hv;
        logic signed [15:0]  s;
        sender_idle_pct    = send_pct;
        receiver_stall_pct = recv_pct;
        sent = 0;
        while (sent < ITEMS_PER_MODE) begin
            pick = $urandom_range(0, 9);
            if (pick < 7)      w = $urandom_range(2, 8);
            else if (pick < 9) w = $urandom_range(0, 1);
            else               w = $urandom_range(9, 24);
            pick = $urandom_range(0, 9);
            if (pick < 8)       hgt = $urandom_range(2, 6);
            else if (pick == 8) hgt = $urandom_range(0, 1);
            else                hgt = $urandom_range(1025, 2047);
            pick = $urandom_range(0, 9);
            if (pick == 0)      s = 16'sh7FFF;
            else if (pick == 1) s = 16'sh8000;
            else if (pick < 5)  s = 16'($urandom());
            else begin
                s = 16'($urandom_range(0, 700));
                if ($urandom_range(0, 1) == 1) s = -s;
            end
            write_geometry(w, hgt, s);
            if ($urandom_range(0, 7) == 0) begin
                write_register(UNUSED_REG_ADDR, $urandom());
            end
            // whole frames, sometimes cut short, never reaching far down a tall frame
            if (hgt > MAX_H) begin
                items = dim_in_use(w, MAX_W) * $urandom_range(2, 4);
            end else begin
                items = dim_in_use(w, MAX_W) * dim_in_use(hgt, MAX_H) * $urandom_range(1, 2)
                        + $urandom_range(0, 3);
            end
            if ($urandom_range(0, 4) == 0) items = $urandom_range(1, items);
            if (items > 150) items = 150;
            if (items > ITEMS_PER_MODE - sent) items = ITEMS_PER_MODE - sent;
            ramp = $urandom_range(0, 1);
            hv   = 8'($urandom());
            repeat (items) begin
                hv = ramp ? hv + 8'($urandom_range(0, 8)) - 8'd4 : 8'($urandom());
                send_height(hv);
                sent++;
            end
        end
    endtask

    initial begin
        i_rst_n                = 1'b0;
        psel                   = 1'b0;
        penable                = 1'b0;
        pwrite                 = 1'b0;
        paddr                  = '0;
        pwdata                 = '0;
        height_ch.valid        = 1'b0;
        height_ch.height_value = '0;
        normal_ch.ready        = 1'b0;
        sender_idle_pct        = 0;
        receiver_stall_pct     = 0;
        mismatch_count         = 0;
        cycle_count            = 0;
        cfg_width              = RST_WIDTH;
        cfg_height             = RST_HEIGHT;
        height_scale_q12       = RST_SCALE;
        next_col               = 0;
        next_row               = 0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_reset_defaults();
        test_tiny_frames();
        test_dimension_limits();
        test_unused_register();
        test_largest_frames();
        test_random_traffic(24, 48);
        test_random_traffic(48, 24);
        test_random_traffic(0, 0);
        wait_idle();

        if (mismatch_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
